[hw/rtl/command_queue_remove_by_id_core_defines.svh]
// Assertion macros used by the command queue datapath.
// Each macro expects clk_i and rst_ni to be in scope at the point of use.
`ifndef COMMAND_QUEUE_REMOVE_BY_ID_CORE_DEFINES_SVH
`define COMMAND_QUEUE_REMOVE_BY_ID_CORE_DEFINES_SVH

// Plain property, checked at every rising clock edge out of reset.
`define CQR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define CQR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cqr_pkg.sv]
// Package for the command queue: sizes, opcodes, status and state codes, word types
// and the control and status bundles between controller and datapath.
package cqr_pkg;

  localparam int QueueDepth = 16;
  localparam int IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int PtrW = $clog2(QueueDepth + 2);
  localparam int OccW = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_QUERY  = 2'd3
  } cqr_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } cqr_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SEARCH,
    S_SHIFT,
    S_FINISH
  } cqr_state_e;

  typedef struct packed {
    cqr_op_e     op;
    logic [15:0] cmd_id;
    logic [31:0] identity;
    logic [7:0]  command;
    logic [31:0] payload;
  } cqr_in_t;

  typedef struct packed {
    cqr_status_e status;
    logic        found;
    logic        front_valid;
    logic [15:0] front_id;
    logic [31:0] front_identity;
    logic [7:0]  front_command;
    logic [31:0] front_payload;
    logic [OccW-1:0] occupancy;
  } cqr_out_t;

  typedef struct packed {
    logic [15:0] cmd_id;
    logic [31:0] identity;
    logic [7:0]  command;
    logic [31:0] payload;
  } cqr_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        capture;
    logic        append;
    logic        ptr_clr;
    logic        shift_wr;
    logic        shrink;
    logic        out_load;
    cqr_status_e status;
    logic        found;
  } cqr_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic last;
    logic shift_end;
  } cqr_stat_t;

endpackage

[hw/rtl/cqr_datapath.sv]
// Datapath of the command queue: entry memory, count, scan pointer, front copy
// and the result register. Depends on cqr_pkg and the assertion macro header.
`include "command_queue_remove_by_id_core_defines.svh"

module cqr_datapath
  import cqr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cqr_in_t   in_i,
  input  cqr_ctrl_t ctrl_i,
  output cqr_stat_t stat_o,
  output logic      done_o,
  output cqr_out_t  out_o
);

  cqr_entry_t mem [QueueDepth];
  cqr_entry_t rdata_q;
  cqr_entry_t front_q, front_d;
  cqr_entry_t wr_data;
  logic [15:0] key_q;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [PtrW-1:0] tag_q;
  logic [PtrW-1:0] tag_m1;
  logic [PtrW-1:0] count_ext;
  logic [IdxW-1:0] wr_addr;
  logic            wr_en;
  cqr_out_t        out_q, out_d;
  logic            out_vld_q;

  assign tag_m1    = tag_q - PtrW'(1);
  assign count_ext = PtrW'(count_q);

  assign wr_en   = ctrl_i.append | ctrl_i.shift_wr;
  assign wr_addr = ctrl_i.append ? count_q[IdxW-1:0] : tag_m1[IdxW-1:0];

  always_comb begin
    if (ctrl_i.append) begin
      wr_data.cmd_id   = in_i.cmd_id;
      wr_data.identity = in_i.identity;
      wr_data.command  = in_i.command;
      wr_data.payload  = in_i.payload;
    end else begin
      wr_data = rdata_q;
    end
  end

  // The memory is read every cycle at the scan pointer; tag_q remembers
  // which slot the registered read word came from.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[ptr_q[IdxW-1:0]];
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.append) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.shrink) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign ptr_d = ctrl_i.ptr_clr ? '0 : ptr_q + PtrW'(1);

  // Slot zero is mirrored here so the front word needs no second read port.
  always_comb begin
    front_d = front_q;
    if (ctrl_i.append && (count_q == '0)) begin
      front_d = wr_data;
    end else if (ctrl_i.shift_wr && (tag_m1 == '0)) begin
      front_d = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      tag_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      tag_q     <= ptr_q;
      out_vld_q <= ctrl_i.out_load;
    end
  end

  always_comb begin
    out_d             = out_q;
    out_d.status      = ctrl_i.status;
    out_d.found       = ctrl_i.found;
    out_d.front_valid = (count_q != '0);
    out_d.occupancy   = OccW'(count_q);
    if (count_q != '0) begin
      out_d.front_id       = front_q.cmd_id;
      out_d.front_identity = front_q.identity;
      out_d.front_command  = front_q.command;
      out_d.front_payload  = front_q.payload;
    end else begin
      out_d.front_id       = '0;
      out_d.front_identity = '0;
      out_d.front_command  = '0;
      out_d.front_payload  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    if (ctrl_i.capture) begin
      key_q <= in_i.cmd_id;
    end
    if (ctrl_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CntW'(QueueDepth));
  assign stat_o.match     = (rdata_q.cmd_id == key_q);
  assign stat_o.last      = ((tag_q + PtrW'(1)) == count_ext);
  assign stat_o.shift_end = (tag_q == count_ext);

  assign done_o = out_vld_q;
  assign out_o  = out_q;

  `CQR_ASSERT(a_count_bound, count_q <= CntW'(QueueDepth), "entry count above queue depth")
  `CQR_ASSERT_IMP(a_shift_in_range, ctrl_i.shift_wr, (tag_q != '0) && (tag_q < count_ext),
                  "compaction write outside the held entries")
  `CQR_ASSERT_IMP(a_full_not_found, out_vld_q, (out_q.status != ST_FULL) || !out_q.found,
                  "full status reported together with found")

endmodule

[hw/rtl/cqr_controller.sv]
// Controller of the command queue: sequences append, peek, search and
// compaction. Depends on cqr_pkg; drives the datapath through cqr_ctrl_t.
module cqr_controller
  import cqr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  cqr_op_e   op_i,
  input  cqr_stat_t stat_i,
  output cqr_ctrl_t ctrl_o,
  output logic      busy
);

  cqr_state_e  state_q, state_d;
  cqr_op_e     op_q, op_d;
  cqr_status_e res_status_q, res_status_d;
  logic        res_found_q, res_found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_PEEK;
      res_status_q <= ST_OK;
      res_found_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d        = op_i;
          res_found_d = 1'b0;
          state_d     = S_FINISH;
          case (op_i)
            OP_APPEND: res_status_d = stat_i.full ? ST_FULL : ST_OK;
            OP_PEEK:   res_status_d = stat_i.empty ? ST_MISS : ST_OK;
            default: begin
              if (stat_i.empty) begin
                res_status_d = ST_MISS;
              end else begin
                state_d = S_FILL;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat_i.match) begin
          res_status_d = ST_OK;
          res_found_d  = 1'b1;
          state_d      = (op_q == OP_REMOVE) ? S_SHIFT : S_FINISH;
        end else if (stat_i.last) begin
          res_status_d = ST_MISS;
          state_d      = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.status = res_status_q;
    ctrl_o.found  = res_found_q;
    busy          = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy           = 1'b0;
        ctrl_o.capture = start;
        ctrl_o.ptr_clr = 1'b1;
        ctrl_o.append  = start && (op_i == OP_APPEND) && !stat_i.full;
      end
      S_FILL, S_SEARCH: begin
        ctrl_o.shift_wr = 1'b0;
      end
      S_SHIFT: begin
        // Each cycle moves the word read from slot tag down by one slot.
        ctrl_o.shift_wr = !stat_i.shift_end;
        ctrl_o.shrink   = stat_i.shift_end;
      end
      S_FINISH: begin
        ctrl_o.out_load = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[hw/rtl/command_queue_remove_by_id_core.sv]
// Top level of the command queue with removal by id.
// Depends on cqr_pkg, cqr_controller and cqr_datapath.
//
// A word is taken when start is high and busy is low. Its result appears on
// out_o for exactly one cycle with done_o high and must be taken then; the
// receiver cannot stall. Append and peek pass from idle through the finish
// state, which loads the result register. Query and remove scan the entry
// memory from the front, one slot per cycle through its single read port;
// a remove then holds busy while the same port moves every later entry down
// one slot. A new word may be started in the cycle its predecessor's result
// is shown.
module command_queue_remove_by_id_core
  import cqr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cqr_in_t  in_i,
  output logic     done_o,
  output cqr_out_t out_o
);

  cqr_ctrl_t ctrl;
  cqr_stat_t stat;

  cqr_controller u_controller (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (in_i.op),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  cqr_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .done_o (done_o),
    .out_o  (out_o)
  );

endmodule
